>>> rtl/core/smm_pkg.sv
// Package for the square matrix multiply unit: command codes, field types,
// and the microcode ROM that sequences the shared multiply-accumulate unit.
// No dependencies.
package smm_pkg;

  localparam int PROD_W = 34;
  localparam int STEP_W = 3;

  typedef logic [1:0]               cmd_t;
  typedef logic [1:0]               idx_t;
  typedef logic signed [15:0]       value_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [STEP_W-1:0]        step_t;
  typedef logic [2:0]               cond_t;

  localparam cmd_t CMD_WRITE_A = 2'd0;
  localparam cmd_t CMD_WRITE_B = 2'd1;
  localparam cmd_t CMD_COMPUTE = 2'd2;

  // Sequencer steps
  localparam step_t ST_IDLE = 3'd0;
  localparam step_t ST_READ = 3'd1;
  localparam step_t ST_MUL  = 3'd2;
  localparam step_t ST_ACC  = 3'd3;
  localparam step_t ST_WAIT = 3'd4;
  localparam step_t ST_EMIT = 3'd5;
  localparam step_t ST_DONE = 3'd6;

  // Jump conditions
  localparam cond_t C_NEXT      = 3'd0;
  localparam cond_t C_ALWAYS    = 3'd1;
  localparam cond_t C_NO_START  = 3'd2;
  localparam cond_t C_K_MORE    = 3'd3;
  localparam cond_t C_OUT_BUSY  = 3'd4;
  localparam cond_t C_ELEM_MORE = 3'd5;

  typedef struct packed {
    logic  accept_en;
    logic  mul_en;
    logic  acc_en;
    logic  emit_en;
    cond_t cond;
    step_t target;
  } uctl_t;

  function automatic uctl_t ucode(input step_t step);
    uctl_t uc;
    unique case (step)
      ST_IDLE: uc = '{1'b1, 1'b0, 1'b0, 1'b0, C_NO_START,  ST_IDLE};
      ST_READ: uc = '{1'b0, 1'b0, 1'b0, 1'b0, C_NEXT,      ST_IDLE};
      ST_MUL:  uc = '{1'b0, 1'b1, 1'b0, 1'b0, C_NEXT,      ST_IDLE};
      ST_ACC:  uc = '{1'b0, 1'b0, 1'b1, 1'b0, C_K_MORE,    ST_READ};
      ST_WAIT: uc = '{1'b0, 1'b0, 1'b0, 1'b0, C_OUT_BUSY,  ST_WAIT};
      ST_EMIT: uc = '{1'b0, 1'b0, 1'b0, 1'b1, C_ELEM_MORE, ST_READ};
      ST_DONE: uc = '{1'b0, 1'b0, 1'b0, 1'b0, C_ALWAYS,    ST_IDLE};
      default: uc = '{1'b0, 1'b0, 1'b0, 1'b0, C_ALWAYS,    ST_IDLE};
    endcase
    return uc;
  endfunction

endpackage

>>> rtl/core/smm_in_if.sv
// Command channel of the square matrix multiply unit: valid/ready plus the
// command, element position and element value. Depends on smm_pkg.
interface smm_in_if import smm_pkg::*; ();
  logic   valid;
  logic   ready;
  cmd_t   command;
  idx_t   row;
  idx_t   col;
  value_t value;

  modport source (output valid, command, row, col, value, input ready);
  modport sink   (input valid, command, row, col, value, output ready);
endinterface

>>> rtl/core/smm_out_if.sv
// Result channel of the square matrix multiply unit: valid/ready plus the
// product element, its position and the last flag. Depends on smm_pkg.
interface smm_out_if import smm_pkg::*; ();
  logic  valid;
  logic  ready;
  idx_t  out_row;
  idx_t  out_col;
  prod_t product;
  logic  last;

  modport source (output valid, out_row, out_col, product, last, input ready);
  modport sink   (input valid, out_row, out_col, product, last, output ready);
endinterface

>>> rtl/core/smm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/square_matrix_multiply_unit.sv
// Square signed matrix multiplier, DIM x DIM, one shared multiply-accumulate unit.
// Writes: accepted in consecutive cycles while idle.
// Compute: each product element takes a RAM read, multiply and accumulate per
// term, then an output handoff; a run holds the input until it is back in idle,
// output stalls included. Rate is set by the single multiplier and one read port per matrix.
// Reset (rst_n, synchronous) clears the sequencer and output valid; matrices stay undefined.
module square_matrix_multiply_unit import smm_pkg::*; #(
  parameter int DIM        = 4,
  parameter int ELEM_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  smm_in_if.sink           in_chan,
  smm_out_if.source        out_chan
);

  localparam int IDX_W       = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int DEPTH       = DIM * DIM;
  localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_FULL_W = 2 * ELEM_WIDTH;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIM - 1);

  step_t upc_r, upc_nxt;
  uctl_t ctl;
  logic  cond_hit;

  logic [IDX_W-1:0] i_r, j_r, k_r;
  logic [IDX_W+1:0] i_wide, j_wide;

  logic                    in_fire;
  logic [7:0]              wr_full;
  logic                    wr_in_range;
  logic [ADDR_W-1:0]       wr_addr;
  logic [ELEM_WIDTH-1:0]   wr_elem;
  logic                    we_a, we_b;
  logic [ADDR_W-1:0]       rd_addr_a, rd_addr_b;
  logic [ELEM_WIDTH-1:0]   a_rd, b_rd;

  logic signed [PROD_FULL_W-1:0] mul_r;
  prod_t                         acc_r;
  logic                          elem_last;

  logic  out_valid_r;
  idx_t  out_row_r, out_col_r;
  prod_t product_r;
  logic  last_r;

  assign ctl = ucode(upc_r);

  // Command side
  assign in_chan.ready = ctl.accept_en;
  assign in_fire       = in_chan.valid && ctl.accept_en;
  assign wr_full       = 8'(in_chan.row) * 8'(DIM) + 8'(in_chan.col);
  assign wr_in_range   = (32'(in_chan.row) < DIM) && (32'(in_chan.col) < DIM);
  assign wr_addr       = ADDR_W'(wr_full);
  assign wr_elem       = ELEM_WIDTH'(in_chan.value);
  assign we_a = in_fire && (in_chan.command == CMD_WRITE_A) && wr_in_range;
  assign we_b = in_fire && (in_chan.command == CMD_WRITE_B) && wr_in_range;

  // A is read along row i, B down column j
  assign rd_addr_a = ADDR_W'(32'(i_r) * DIM + 32'(k_r));
  assign rd_addr_b = ADDR_W'(32'(k_r) * DIM + 32'(j_r));

  smm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_mat_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (wr_addr),
    .wdata (wr_elem),
    .raddr (rd_addr_a),
    .rdata (a_rd)
  );

  smm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_mat_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (wr_addr),
    .wdata (wr_elem),
    .raddr (rd_addr_b),
    .rdata (b_rd)
  );

  assign elem_last = (i_r == IDX_LAST) && (j_r == IDX_LAST);

  // Step counter with conditional jump
  always_comb begin
    unique case (ctl.cond)
      C_NEXT:      cond_hit = 1'b0;
      C_ALWAYS:    cond_hit = 1'b1;
      C_NO_START:  cond_hit = !(in_fire && (in_chan.command == CMD_COMPUTE));
      C_K_MORE:    cond_hit = (k_r != IDX_LAST);
      C_OUT_BUSY:  cond_hit = out_valid_r && !out_chan.ready;
      C_ELEM_MORE: cond_hit = !elem_last;
      default:     cond_hit = 1'b0;
    endcase
    upc_nxt = cond_hit ? ctl.target : step_t'(upc_r + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= ST_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  // Loop indices: restart on every accepted command
  always_ff @(posedge clk) begin
    if (in_fire) begin
      i_r <= '0;
      j_r <= '0;
      k_r <= '0;
    end else begin
      if (ctl.acc_en) begin
        k_r <= (k_r == IDX_LAST) ? '0 : IDX_W'(k_r + 1'b1);
      end
      if (ctl.emit_en) begin
        if (j_r == IDX_LAST) begin
          j_r <= '0;
          i_r <= (i_r == IDX_LAST) ? '0 : IDX_W'(i_r + 1'b1);
        end else begin
          j_r <= IDX_W'(j_r + 1'b1);
        end
      end
    end
  end

  // Shared multiply-accumulate; the first term of a dot product starts fresh
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      mul_r <= PROD_FULL_W'($signed(a_rd)) * PROD_FULL_W'($signed(b_rd));
    end
    if (ctl.acc_en) begin
      acc_r <= ((k_r == '0) ? prod_t'(0) : acc_r) + PROD_W'(mul_r);
    end
  end

  // Output register
  assign i_wide = (IDX_W + 2)'(i_r);
  assign j_wide = (IDX_W + 2)'(j_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit_en) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_en) begin
      out_row_r <= i_wide[1:0];
      out_col_r <= j_wide[1:0];
      product_r <= acc_r;
      last_r    <= elem_last;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.out_row = out_row_r;
  assign out_chan.out_col = out_col_r;
  assign out_chan.product = product_r;
  assign out_chan.last    = last_r;

endmodule

>>> rtl/core/smm_checker.sv
// Port-level checks for the square matrix multiply unit, bound to the top level.
// Depends on smm_pkg and square_matrix_multiply_unit.
module smm_checker import smm_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input cmd_t in_command,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);

  // A pending result holds until transferred
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped before transfer");

  // A compute transfer closes the command side at once
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == CMD_COMPUTE) |=> !in_ready)
    else $error("command accepted right after compute");

  // No command is taken in the middle of a product run
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("command accepted during product run");

  // Writes and unused codes produce no result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command != CMD_COMPUTE) && !out_valid |=> !out_valid)
    else $error("result after non-compute command");

endmodule

bind square_matrix_multiply_unit smm_checker u_smm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .in_command (in_chan.command),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_last   (out_chan.last)
);
